>>> hdl/ssmo_pkg.sv
`default_nettype none

package ssmo_pkg;

  localparam int unsigned SetSize = 32;
  localparam int unsigned AddrW   = $clog2(SetSize);
  localparam int unsigned CntW    = $clog2(SetSize + 1);

  typedef enum logic [2:0] {
    OpLoadA    = 3'd0,
    OpLoadB    = 3'd1,
    OpLoadU    = 3'd2,
    OpClear    = 3'd3,
    OpUnion    = 3'd4,
    OpInter    = 3'd5,
    OpDiff     = 3'd6,
    OpCompl    = 3'd7
  } opcode_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] element;
  } in_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       empty_res;
    logic       last;
    logic       overflow;
  } out_req_t;

endpackage

`default_nettype wire

>>> hdl/ssmo_ram.sv
`default_nettype none

module ssmo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/sorted_set_merge_ops_top.sv
`default_nettype none

// Three ascending byte sets (A, B, universe) of up to 32 entries each, kept in
// single-port-read RAMs. A load or clear request is taken straight from idle. An
// operation request (union, intersect, A minus B, complement of A) runs a
// two-pointer merge: each merge step is a registered RAM read followed by a
// compare, and the number of steps is at most one more than the sum of the two
// set counts that the operation walks. An operation holds the input stalled
// until it finishes, and longer while the output is stalled. Results leave
// through an output register with one element held back so the final one can
// be marked last; an empty result gives one item with empty_res set.

module sorted_set_merge_ops_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ssmo_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ssmo_pkg::out_req_t     out_req_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCmp  = 2'd2;

  logic [1:0]                    state_q, state_d;
  ssmo_pkg::opcode_e             op_q, op_d;
  logic [ssmo_pkg::CntW-1:0]     i_q, i_d, j_q, j_d;
  logic [ssmo_pkg::CntW-1:0]     cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d, cnt_u_q, cnt_u_d;
  logic                          ovf_q, ovf_d;
  logic                          pend_v_q, pend_v_d;
  logic [7:0]                    pend_val_q, pend_val_d;
  logic                          out_v_q, out_v_d;
  ssmo_pkg::out_req_t            out_q, out_d;

  logic                          we_a, we_b, we_u;
  logic [7:0]                    rd_a, rd_b, rd_u, rd_2;
  logic                          ia, jb, lt, eq;
  logic                          emit_v, step_done, adv_i, adv_j, out_free;
  logic [7:0]                    emit_val;

  ssmo_ram #(.Width(8), .Depth(ssmo_pkg::SetSize)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[ssmo_pkg::AddrW-1:0]),
    .wdata_i (in_req_i.element),
    .raddr_i (i_q[ssmo_pkg::AddrW-1:0]),
    .rdata_o (rd_a)
  );

  ssmo_ram #(.Width(8), .Depth(ssmo_pkg::SetSize)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[ssmo_pkg::AddrW-1:0]),
    .wdata_i (in_req_i.element),
    .raddr_i (j_q[ssmo_pkg::AddrW-1:0]),
    .rdata_o (rd_b)
  );

  ssmo_ram #(.Width(8), .Depth(ssmo_pkg::SetSize)) u_ram_u (
    .clk_i   (clk_i),
    .we_i    (we_u),
    .waddr_i (cnt_u_q[ssmo_pkg::AddrW-1:0]),
    .wdata_i (in_req_i.element),
    .raddr_i (j_q[ssmo_pkg::AddrW-1:0]),
    .rdata_o (rd_u)
  );

  always_comb begin
    rd_2      = (op_q == ssmo_pkg::OpCompl) ? rd_u : rd_b;
    ia        = i_q < cnt_a_q;
    jb        = j_q < ((op_q == ssmo_pkg::OpCompl) ? cnt_u_q : cnt_b_q);
    lt        = rd_a < rd_2;
    eq        = rd_a == rd_2;
    emit_v    = 1'b0;
    emit_val  = rd_a;
    adv_i     = 1'b0;
    adv_j     = 1'b0;
    step_done = 1'b0;
    case (op_q)
      ssmo_pkg::OpUnion: begin
        if (ia && jb) begin
          emit_v   = 1'b1;
          emit_val = lt ? rd_a : rd_2;
          adv_i    = lt || eq;
          adv_j    = !lt;
        end else if (ia) begin
          emit_v = 1'b1;
          adv_i  = 1'b1;
        end else if (jb) begin
          emit_v   = 1'b1;
          emit_val = rd_2;
          adv_j    = 1'b1;
        end else begin
          step_done = 1'b1;
        end
      end
      ssmo_pkg::OpInter: begin
        if (ia && jb) begin
          emit_v = eq;
          adv_i  = lt || eq;
          adv_j  = !lt;
        end else begin
          step_done = 1'b1;
        end
      end
      ssmo_pkg::OpDiff: begin
        if (ia && jb) begin
          emit_v = lt;
          adv_i  = lt || eq;
          adv_j  = !lt;
        end else if (ia) begin
          emit_v = 1'b1;
          adv_i  = 1'b1;
        end else begin
          step_done = 1'b1;
        end
      end
      ssmo_pkg::OpCompl: begin
        if (jb) begin
          if (ia && lt) begin
            adv_i = 1'b1;
          end else if (ia && eq) begin
            adv_i = 1'b1;
            adv_j = 1'b1;
          end else begin
            emit_v   = 1'b1;
            emit_val = rd_2;
            adv_j    = 1'b1;
          end
        end else begin
          step_done = 1'b1;
        end
      end
      default: begin
        step_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    i_d        = i_q;
    j_d        = j_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    cnt_u_d    = cnt_u_q;
    ovf_d      = ovf_q;
    pend_v_d   = pend_v_q;
    pend_val_d = pend_val_q;
    out_d      = out_q;
    we_a       = 1'b0;
    we_b       = 1'b0;
    we_u       = 1'b0;
    out_free   = !out_v_q || !out_stall_i;
    out_v_d    = out_v_q && out_stall_i;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (in_req_i.opcode)
            ssmo_pkg::OpLoadA: begin
              if (cnt_a_q < ssmo_pkg::CntW'(ssmo_pkg::SetSize)) begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + ssmo_pkg::CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ssmo_pkg::OpLoadB: begin
              if (cnt_b_q < ssmo_pkg::CntW'(ssmo_pkg::SetSize)) begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + ssmo_pkg::CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ssmo_pkg::OpLoadU: begin
              if (cnt_u_q < ssmo_pkg::CntW'(ssmo_pkg::SetSize)) begin
                we_u    = 1'b1;
                cnt_u_d = cnt_u_q + ssmo_pkg::CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ssmo_pkg::OpClear: begin
              cnt_a_d = '0;
              cnt_b_d = '0;
              cnt_u_d = '0;
              ovf_d   = 1'b0;
            end
            default: begin
              op_d     = in_req_i.opcode;
              i_d      = '0;
              j_d      = '0;
              pend_v_d = 1'b0;
              state_d  = StRead;
            end
          endcase
        end
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (step_done) begin
          if (out_free) begin
            out_v_d         = 1'b1;
            out_d.value     = pend_v_q ? pend_val_q : 8'd0;
            out_d.empty_res = !pend_v_q;
            out_d.last      = 1'b1;
            out_d.overflow  = ovf_q;
            pend_v_d        = 1'b0;
            state_d         = StIdle;
          end
        end else if (!(emit_v && pend_v_q && !out_free)) begin
          // flush the held element before taking the new one
          if (emit_v) begin
            if (pend_v_q) begin
              out_v_d         = 1'b1;
              out_d.value     = pend_val_q;
              out_d.empty_res = 1'b0;
              out_d.last      = 1'b0;
              out_d.overflow  = ovf_q;
            end
            pend_v_d   = 1'b1;
            pend_val_d = emit_val;
          end
          i_d     = i_q + ssmo_pkg::CntW'(adv_i);
          j_d     = j_q + ssmo_pkg::CntW'(adv_j);
          state_d = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      op_q     <= ssmo_pkg::OpUnion;
      i_q      <= '0;
      j_q      <= '0;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      cnt_u_q  <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      i_q      <= i_d;
      j_q      <= j_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      cnt_u_q  <= cnt_u_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_val_q <= pend_val_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> i_q <= cnt_a_q)
    else $error("A pointer ran past the A count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_a_q <= ssmo_pkg::CntW'(ssmo_pkg::SetSize) &&
    cnt_b_q <= ssmo_pkg::CntW'(ssmo_pkg::SetSize) &&
    cnt_u_q <= ssmo_pkg::CntW'(ssmo_pkg::SetSize))
    else $error("set count above capacity");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.empty_res |-> out_req_o.last && out_req_o.value == 8'd0)
    else $error("empty result not a single zero last item");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !pend_v_q)
    else $error("held result left behind after operation");

endmodule

`default_nettype wire

>>> tb/sv/tb_sorted_set_merge_ops_top.sv
`default_nettype none

module tb_sorted_set_merge_ops_top;
  import ssmo_pkg::*;

  localparam int ItemTarget  = 380;
  localparam int IdlePct     = 28;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 200;
  localparam int WatchLimit  = 2000;

  typedef enum int {
    SeqSorted,
    SeqNoisy,
    SeqOverflow
  } seq_kind_e;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  logic [7:0] set_a [SetSize];
  logic [7:0] set_b [SetSize];
  logic [7:0] set_u [SetSize];
  int         cnt_a = 0;
  int         cnt_b = 0;
  int         cnt_u = 0;
  logic       ovf_flag = 1'b0;

  out_req_t merge_results_q[$];
  out_req_t want_res;
  int       mismatches = 0;
  int       sent_items = 0;
  int       quiet_cycles = 0;
  int       hold_left = 0;
  bit       no_idle = 1'b0;

  sorted_set_merge_ops_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_merge(in_req_t req);
    logic [7:0] vals[$];
    int         i;
    int         j;
    int         k;
    i = 0;
    j = 0;
    case (req.opcode)
      OpLoadA: begin
        if (cnt_a < SetSize) begin
          set_a[cnt_a] = req.element;
          cnt_a++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OpLoadB: begin
        if (cnt_b < SetSize) begin
          set_b[cnt_b] = req.element;
          cnt_b++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OpLoadU: begin
        if (cnt_u < SetSize) begin
          set_u[cnt_u] = req.element;
          cnt_u++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OpClear: begin
        cnt_a = 0;
        cnt_b = 0;
        cnt_u = 0;
        ovf_flag = 1'b0;
      end
      OpUnion: begin
        while (i < cnt_a && j < cnt_b) begin
          if (set_a[i] < set_b[j]) begin
            vals.push_back(set_a[i]);
            i++;
          end else if (set_a[i] > set_b[j]) begin
            vals.push_back(set_b[j]);
            j++;
          end else begin
            vals.push_back(set_a[i]);
            i++;
            j++;
          end
        end
        while (i < cnt_a) begin
          vals.push_back(set_a[i]);
          i++;
        end
        while (j < cnt_b) begin
          vals.push_back(set_b[j]);
          j++;
        end
      end
      OpInter: begin
        while (i < cnt_a && j < cnt_b) begin
          if (set_a[i] < set_b[j]) begin
            i++;
          end else if (set_a[i] > set_b[j]) begin
            j++;
          end else begin
            vals.push_back(set_a[i]);
            i++;
            j++;
          end
        end
      end
      OpDiff: begin
        while (i < cnt_a && j < cnt_b) begin
          if (set_a[i] < set_b[j]) begin
            vals.push_back(set_a[i]);
            i++;
          end else if (set_a[i] > set_b[j]) begin
            j++;
          end else begin
            i++;
            j++;
          end
        end
        while (i < cnt_a) begin
          vals.push_back(set_a[i]);
          i++;
        end
      end
      default: begin
        for (j = 0; j < cnt_u; j++) begin
          while (i < cnt_a && set_a[i] < set_u[j]) i++;
          if (i < cnt_a && set_a[i] == set_u[j]) begin
            i++;
          end else begin
            vals.push_back(set_u[j]);
          end
        end
      end
    endcase
    if (req.opcode >= OpUnion) begin
      if (vals.size() == 0) begin
        merge_results_q.push_back('{value: 8'h00, empty_res: 1'b1, last: 1'b1,
                                    overflow: ovf_flag});
      end else begin
        for (k = 0; k < vals.size(); k++) begin
          merge_results_q.push_back('{value: vals[k], empty_res: 1'b0,
                                      last: (k == vals.size() - 1), overflow: ovf_flag});
        end
      end
    end
  endtask

  always @(posedge clk) begin
    quiet_cycles++;
    if (rst_n && in_valid && in_stall === 1'b0) begin
      predict_merge(in_req);
      quiet_cycles = 0;
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      quiet_cycles = 0;
      if (merge_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual value %h empty %b last %b ovf %b",
                 $time, out_req.value, out_req.empty_res, out_req.last, out_req.overflow);
      end else begin
        want_res = merge_results_q.pop_front();
        if (out_req.value !== want_res.value || out_req.empty_res !== want_res.empty_res ||
            out_req.last !== want_res.last || out_req.overflow !== want_res.overflow) begin
          mismatches++;
          $display("%0t: result mismatch: expected value %h empty %b last %b ovf %b,",
                   $time, want_res.value, want_res.empty_res, want_res.last, want_res.overflow);
          $display("%0t:   actual value %h empty %b last %b ovf %b",
                   $time, out_req.value, out_req.empty_res, out_req.last, out_req.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < IdlePct);
    end
  end

  initial begin
    wait (quiet_cycles >= WatchLimit);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_req(opcode_e op, logic [7:0] el);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{opcode: op, element: el};
    sent_items++;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  function automatic int pick_len();
    return ($urandom_range(7) == 0) ? $urandom_range(16, SetSize) : $urandom_range(0, 8);
  endfunction

  task automatic build_set(seq_kind_e kind, int len, int start, int stride,
                           ref logic [7:0] q[$]);
    int v;
    v = start;
    q.delete();
    repeat (len) begin
      if (kind == SeqNoisy) begin
        q.push_back(8'($urandom_range(255)));
      end else if (v <= 255) begin
        q.push_back(v[7:0]);
        v += $urandom_range(1, stride);
      end
    end
  endtask

  task automatic run_sequence(seq_kind_e kind);
    logic [7:0] qa[$];
    logic [7:0] qb[$];
    logic [7:0] qu[$];
    int         start;
    int         stride;
    int         len_a;
    int         len_b;
    int         len_u;
    int         full_set;
    opcode_e    op;
    if (kind != SeqNoisy || $urandom_range(1) == 1) send_req(OpClear, 8'($urandom_range(255)));
    start  = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 180);
    stride = ($urandom_range(3) == 0) ? 16 : 3;
    len_a  = pick_len();
    len_b  = pick_len();
    len_u  = pick_len();
    if (kind == SeqOverflow) begin
      start    = $urandom_range(0, 20);
      stride   = 2;
      full_set = $urandom_range(2);
      if (full_set == 0) len_a = SetSize + $urandom_range(1, 3);
      if (full_set == 1) len_b = SetSize + $urandom_range(1, 3);
      if (full_set == 2) len_u = SetSize + $urandom_range(1, 3);
    end
    build_set(kind, len_a, start, stride, qa);
    build_set(kind, len_b, start, stride, qb);
    build_set(kind, len_u, start, (stride > 2) ? stride - 1 : stride, qu);
    while (qa.size() + qb.size() + qu.size() > 0) begin
      case ($urandom_range(2))
        0: if (qa.size() > 0) send_req(OpLoadA, qa.pop_front());
        1: if (qb.size() > 0) send_req(OpLoadB, qb.pop_front());
        default: if (qu.size() > 0) send_req(OpLoadU, qu.pop_front());
      endcase
    end
    repeat ($urandom_range(2, 6)) begin
      if (kind == SeqNoisy) begin
        op = opcode_e'($urandom_range(7));
      end else begin
        op = opcode_e'($urandom_range(int'(OpUnion), int'(OpCompl)));
      end
      send_req(op, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_empty_results();
    send_req(OpUnion, 8'h00);
    send_req(OpInter, 8'hff);
    send_req(OpDiff, 8'h00);
    send_req(OpCompl, 8'hff);
  endtask

  // universe lacks A's 3 and ends before A's 255
  task automatic test_directed_merge();
    send_req(OpLoadA, 8'h00);
    send_req(OpLoadA, 8'h03);
    send_req(OpLoadA, 8'h05);
    send_req(OpLoadA, 8'hff);
    send_req(OpLoadB, 8'h05);
    send_req(OpLoadB, 8'h07);
    send_req(OpLoadB, 8'hff);
    send_req(OpLoadU, 8'h00);
    send_req(OpLoadU, 8'h05);
    send_req(OpLoadU, 8'h07);
    send_req(OpLoadU, 8'h80);
    send_req(OpUnion, 8'h00);
    send_req(OpInter, 8'h00);
    send_req(OpDiff, 8'h00);
    send_req(OpCompl, 8'h00);
    send_req(OpClear, 8'hff);
    send_req(OpUnion, 8'hff);
  endtask

  task automatic test_overflow();
    run_sequence(SeqOverflow);
    run_sequence(SeqOverflow);
  endtask

  // hold the receiver so pending results back up into the input
  task automatic test_backpressure();
    hold_left = HoldCycles;
    send_req(OpLoadA, 8'h10);
    send_req(OpLoadB, 8'h20);
    send_req(OpUnion, 8'h00);
    send_req(OpDiff, 8'h00);
    send_req(OpInter, 8'h00);
    run_sequence(SeqSorted);
  endtask

  task automatic test_streaming();
    no_idle = 1'b1;
    run_sequence(SeqSorted);
    run_sequence(SeqSorted);
    no_idle = 1'b0;
  endtask

  task automatic test_random_sets();
    int kind_pick;
    while (sent_items < ItemTarget) begin
      kind_pick = $urandom_range(9);
      if (kind_pick < 7) run_sequence(SeqSorted);
      else if (kind_pick < 9) run_sequence(SeqNoisy);
      else run_sequence(SeqOverflow);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_results();
    test_directed_merge();
    test_overflow();
    test_backpressure();
    test_streaming();
    test_random_sets();
    in_valid <= 1'b0;
    while (merge_results_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
